// ===== src/pdpc_pkg.sv =====
// pdpc_pkg: shared constants and controller/datapath interface types
// for the per-destination packet counter; no dependencies
`default_nettype none

package pdpc_pkg;

  // table geometry
  localparam int TABLE_ENTRIES = 64;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

  // word field widths
  localparam int ADDR_W  = 32;
  localparam int COUNT_W = 64;

  // commands from controller to datapath
  typedef struct packed {
    logic load;      // latch address, restart the scan
    logic scan;      // read the next entry, shift the compare stage
    logic hit_upd;   // bump the matched entry and emit its count
    logic miss_upd;  // claim a free entry or report a full table
  } pdpc_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic used_zero; // no entry claimed yet
    logic match;     // compare stage holds a valid entry equal to the address
    logic rd_vld;    // compare stage holds a claimed entry
    logic rd_last;   // compare stage holds the last claimed entry
  } pdpc_status_t;

endpackage : pdpc_pkg

`default_nettype wire

// ===== src/per_destination_packet_counter_unit.sv =====
// per_destination_packet_counter_unit: top level, joins controller and datapath
// depends on pdpc_pkg, pdpc_ctrl, pdpc_datapath
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+--------------------------------------
//  input    | start_i / busy_o          | dest_address_i[31:0]
//  result   | result_valid_o (strobe)   | packet_count_o[63:0], new_entry_o,
//           |                           | table_full_o
//
// a word taken while n entries are claimed is answered after the load, the scan
// of the claimed entries up to the matched one on a hit or of all n on a miss,
// and the update; the scan reads one entry a cycle from the address memory.
// busy_o is high from the cycle after accept until the result is written; the
// strobe lasts one cycle and cannot be held off.
// reset empties the table at once through the fill count, no clearing pass.
`default_nettype none

module per_destination_packet_counter_unit import pdpc_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  output logic                    busy_o,
  input  wire logic [ADDR_W-1:0]  dest_address_i,
  output logic                    result_valid_o,
  output logic [COUNT_W-1:0]      packet_count_o,
  output logic                    new_entry_o,
  output logic                    table_full_o
);

  pdpc_cmd_t    cmd;
  pdpc_status_t status;
  logic         start_acc;

  // controller
  pdpc_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  // datapath
  pdpc_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .dest_address_i (dest_address_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .result_valid_o (result_valid_o),
    .packet_count_o (packet_count_o),
    .new_entry_o    (new_entry_o),
    .table_full_o   (table_full_o)
  );

  assign start_acc = start_i && !busy_o;

`ifndef SYNTHESIS
  // accepted word always starts a lookup
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_acc |=> busy_o)
    else $error("busy not raised after accept");

  // results are isolated single-cycle strobes
  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe longer than one cycle");

  // full table reports a new address with zero count
  a_full_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && table_full_o) |-> (new_entry_o && packet_count_o == '0))
    else $error("full table result malformed");

  // a hit never reports a zero count
  a_hit_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !new_entry_o) |-> (packet_count_o != '0 && !table_full_o))
    else $error("hit result malformed");
`endif

endmodule : per_destination_packet_counter_unit

`default_nettype wire

// ===== src/pdpc_datapath.sv =====
// pdpc_datapath: address and count memories, scan counter, compare stage,
// saturating update and result registers; depends on pdpc_pkg
`default_nettype none

module pdpc_datapath import pdpc_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic [ADDR_W-1:0]  dest_address_i,
  input  wire pdpc_cmd_t          cmd_i,
  output pdpc_status_t            status_o,
  output logic                    result_valid_o,
  output logic [COUNT_W-1:0]      packet_count_o,
  output logic                    new_entry_o,
  output logic                    table_full_o
);

  // table memories, no reset: only claimed entries are ever compared
  logic [ADDR_W-1:0]  addr_mem [TABLE_ENTRIES];
  logic [COUNT_W-1:0] cnt_mem  [TABLE_ENTRIES];

  logic [CNT_W-1:0]   used_q, used_d;
  logic [CNT_W-1:0]   scan_idx_q, scan_idx_d;
  logic               rd_vld_q, rd_vld_d;
  logic               res_vld_q;
  logic [ADDR_W-1:0]  key_q;
  logic [IDX_W-1:0]   rd_idx_q;
  logic [ADDR_W-1:0]  addr_rd_q;
  logic [COUNT_W-1:0] cnt_rd_q;
  logic [COUNT_W-1:0] res_cnt_q;
  logic               res_new_q;
  logic               res_full_q;
  logic               full;
  logic [COUNT_W-1:0] cnt_inc;

  assign full = (used_q == CNT_W'(TABLE_ENTRIES));

  // saturating increment of the matched count
  assign cnt_inc = (cnt_rd_q == {COUNT_W{1'b1}}) ? cnt_rd_q : cnt_rd_q + COUNT_W'(1);

  // control next state
  always_comb begin
    used_d     = used_q;
    scan_idx_d = scan_idx_q;
    rd_vld_d   = rd_vld_q;
    if (cmd_i.load) begin
      scan_idx_d = '0;
      rd_vld_d   = 1'b0;
    end else if (cmd_i.scan) begin
      scan_idx_d = scan_idx_q + CNT_W'(1);
      rd_vld_d   = (scan_idx_q < used_q);
    end
    if (cmd_i.miss_upd && !full) begin
      used_d = used_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q     <= '0;
      scan_idx_q <= '0;
      rd_vld_q   <= 1'b0;
      res_vld_q  <= 1'b0;
    end else begin
      used_q     <= used_d;
      scan_idx_q <= scan_idx_d;
      rd_vld_q   <= rd_vld_d;
      res_vld_q  <= cmd_i.hit_upd | cmd_i.miss_upd;
    end
  end

  // address latch and compare stage
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      key_q <= dest_address_i;
    end
    if (cmd_i.scan) begin
      rd_idx_q <= scan_idx_q[IDX_W-1:0];
    end
  end

  // address memory: registered read during the scan, write on claim
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan) begin
      addr_rd_q <= addr_mem[scan_idx_q[IDX_W-1:0]];
    end
    if (cmd_i.miss_upd && !full) begin
      addr_mem[used_q[IDX_W-1:0]] <= key_q;
    end
  end

  // count memory: read alongside the address, write on hit or claim
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan) begin
      cnt_rd_q <= cnt_mem[scan_idx_q[IDX_W-1:0]];
    end
    if (cmd_i.hit_upd) begin
      cnt_mem[rd_idx_q] <= cnt_inc;
    end else if (cmd_i.miss_upd && !full) begin
      cnt_mem[used_q[IDX_W-1:0]] <= COUNT_W'(1);
    end
  end

  // result word
  always_ff @(posedge clk_i) begin
    if (cmd_i.hit_upd) begin
      res_cnt_q  <= cnt_inc;
      res_new_q  <= 1'b0;
      res_full_q <= 1'b0;
    end else if (cmd_i.miss_upd) begin
      res_cnt_q  <= full ? '0 : COUNT_W'(1);
      res_new_q  <= 1'b1;
      res_full_q <= full;
    end
  end

  // status back to the controller
  assign status_o.used_zero = (used_q == '0);
  assign status_o.match     = rd_vld_q && (addr_rd_q == key_q);
  assign status_o.rd_vld    = rd_vld_q;
  assign status_o.rd_last   = (CNT_W'(rd_idx_q) + CNT_W'(1) == used_q);

  assign result_valid_o = res_vld_q;
  assign packet_count_o = res_cnt_q;
  assign new_entry_o    = res_new_q;
  assign table_full_o   = res_full_q;

endmodule : pdpc_datapath

`default_nettype wire

// ===== src/pdpc_ctrl.sv =====
// pdpc_ctrl: controller state machine that sequences load, scan and update;
// depends on pdpc_pkg
`default_nettype none

module pdpc_ctrl import pdpc_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire pdpc_status_t status_i,
  output pdpc_cmd_t         cmd_o,
  output logic              busy_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_HIT  = 2'd2;
  localparam logic [1:0] ST_MISS = 2'd3;

  logic [1:0] state_q, state_d;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        priority if (status_i.used_zero) begin
          state_d = ST_MISS;
        end else if (status_i.match) begin
          state_d = ST_HIT;
        end else if (status_i.rd_vld && status_i.rd_last) begin
          state_d = ST_MISS;
        end else begin
          cmd_o.scan = 1'b1;
        end
      end
      ST_HIT: begin
        cmd_o.hit_upd = 1'b1;
        state_d       = ST_IDLE;
      end
      ST_MISS: begin
        cmd_o.miss_upd = 1'b1;
        state_d        = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule : pdpc_ctrl

`default_nettype wire
